// File: hdl/http_chunked_body_decoder_macros.svh
// assertion macros for the chunked body decoder
`ifndef HTTP_CHUNKED_BODY_DECODER_MACROS_SVH
`define HTTP_CHUNKED_BODY_DECODER_MACROS_SVH

`ifndef SYNTHESIS
`define HCBD_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("hcbd assertion failed");
`define HCBD_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("hcbd assertion failed");
`else
`define HCBD_ASSERT_IMP(label, clk, rst, ante, cons)
`define HCBD_ASSERT_NXT(label, clk, rst, ante, cons)
`endif

`endif

// File: hdl/hcbd_pkg.sv
package hcbd_pkg;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_last;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       end_valid;
      logic [1:0] end_status;
   } rsp_payload_type;

   typedef struct packed {
      logic       ok;
      logic [3:0] value;
   } hex_type;

   localparam logic [2:0] PH_LEAD   = 3'd0;
   localparam logic [2:0] PH_SIGNED = 3'd1;
   localparam logic [2:0] PH_DIGITS = 3'd2;
   localparam logic [2:0] PH_XPREF  = 3'd3;
   localparam logic [2:0] PH_IGNORE = 3'd4;
   localparam logic [2:0] PH_DATA   = 3'd5;
   localparam logic [2:0] PH_TRAIL  = 3'd6;
   localparam logic [2:0] PH_DONE   = 3'd7;

   localparam logic [1:0] END_TERMINATOR = 2'd0;
   localparam logic [1:0] END_BOUNDARY   = 2'd1;
   localparam logic [1:0] END_TRUNCATED  = 2'd2;

   localparam logic [7:0] CHAR_CR    = 8'h0d;
   localparam logic [7:0] CHAR_LF    = 8'h0a;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_VT    = 8'h0b;
   localparam logic [7:0] CHAR_FF    = 8'h0c;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_PLUS  = 8'h2b;
   localparam logic [7:0] CHAR_MINUS = 8'h2d;
   localparam logic [7:0] CHAR_X_LO  = 8'h78;
   localparam logic [7:0] CHAR_X_UP  = 8'h58;

   function automatic hex_type hex_digit(input logic [7:0] b);
      hex_type h;
      h.ok    = 1'b1;
      h.value = 4'd0;
      if (b >= 8'h30 && b <= 8'h39) begin
         h.value = 4'(b - 8'h30);
      end else if (b >= 8'h61 && b <= 8'h66) begin
         h.value = 4'(b - 8'h57);
      end else if (b >= 8'h41 && b <= 8'h46) begin
         h.value = 4'(b - 8'h37);
      end else begin
         h.ok = 1'b0;
      end
      return h;
   endfunction

   function automatic logic is_space(input logic [7:0] b);
      return b == CHAR_SPACE || b == CHAR_TAB || b == CHAR_LF || b == CHAR_VT
         || b == CHAR_FF || b == CHAR_CR;
   endfunction

endpackage

// File: hdl/hcbd_stream_if.sv
interface hcbd_stream_if #(
   parameter type payload_type = logic [7:0]
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// File: hdl/http_chunked_body_decoder.sv
// channel      direction  payload
// req_stream   in         in_byte[7:0], in_last
// rsp_stream   out        out_byte[7:0], byte_valid, end_valid, end_status[1:0]
//
// one byte accepted per cycle unless rsp_stream stalls; any result is registered
// the size-line parse and data count for a byte settle in the single cycle
// between the input register and the result register
// reset is synchronous and returns the parser to the start of a size line
// a stalled result holds the input register, also for a byte that has no result
`include "http_chunked_body_decoder_macros.svh"

module http_chunked_body_decoder #(
   parameter int CHUNK_SIZE_BITS = 32
) (
   input logic         clock,
   input logic         reset,
   hcbd_stream_if.sink   req_stream,
   hcbd_stream_if.source rsp_stream
);

   localparam int N = CHUNK_SIZE_BITS;

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_last_ff;

   logic [2:0]   phase_ff, phase_in;
   logic [N-1:0] acc_ff, acc_in;
   logic         neg_ff, neg_in;
   logic         lz_ff, lz_in;
   logic         crp_ff, crp_in;
   logic [N-1:0] rem_ff, rem_in;

   logic                     out_valid_ff, out_valid_in;
   hcbd_pkg::rsp_payload_type out_ff, out_in;

   logic         process;
   logic         line_go;
   logic         line_done;
   logic         emit;
   hcbd_pkg::hex_type hx;
   logic [N-1:0] acc_digit;

   assign process          = in_valid_ff && (!out_valid_ff || rsp_stream.ready);
   assign req_stream.ready = !in_valid_ff || process;
   assign rsp_stream.valid = out_valid_ff;
   assign rsp_stream.payload = out_ff;

   assign hx        = hcbd_pkg::hex_digit(in_byte_ff);
   assign acc_digit = (acc_ff[N-1:N-4] != 4'd0) ? {N{1'b1}} : {acc_ff[N-5:0], hx.value};

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_stream.valid && req_stream.ready) begin
         in_valid_in = 1'b1;
      end else if (process) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      phase_in  = phase_ff;
      acc_in    = acc_ff;
      neg_in    = neg_ff;
      lz_in     = lz_ff;
      crp_in    = crp_ff;
      rem_in    = rem_ff;
      line_go   = 1'b0;
      line_done = 1'b0;
      out_in.out_byte   = 8'd0;
      out_in.byte_valid = 1'b0;
      out_in.end_valid  = in_last_ff;
      out_in.end_status = hcbd_pkg::END_TERMINATOR;

      unique case (phase_ff)
         hcbd_pkg::PH_DATA: begin
            out_in.out_byte   = in_byte_ff;
            out_in.byte_valid = 1'b1;
            rem_in = rem_ff - {{(N-1){1'b0}}, 1'b1};
            if (rem_in == '0) begin
               phase_in = hcbd_pkg::PH_TRAIL;
            end
         end
         hcbd_pkg::PH_TRAIL: begin
            if (crp_ff) begin
               crp_in   = 1'b0;
               phase_in = hcbd_pkg::PH_LEAD;
               line_go  = (in_byte_ff != hcbd_pkg::CHAR_LF);
            end else if (in_byte_ff == hcbd_pkg::CHAR_CR) begin
               crp_in = 1'b1;
            end else begin
               phase_in = hcbd_pkg::PH_LEAD;
               line_go  = 1'b1;
            end
         end
         hcbd_pkg::PH_DONE: begin
         end
         default: begin
            line_go = 1'b1;
         end
      endcase

      if (line_go) begin
         // a held cr either closes the line or counts as line content
         if (crp_in) begin
            crp_in = 1'b0;
            if (in_byte_ff == hcbd_pkg::CHAR_LF) begin
               line_done = 1'b1;
               if (neg_ff || acc_ff == '0) begin
                  phase_in = hcbd_pkg::PH_DONE;
               end else begin
                  rem_in   = acc_ff;
                  phase_in = hcbd_pkg::PH_DATA;
               end
               acc_in = '0;
               neg_in = 1'b0;
               lz_in  = 1'b0;
            end else if (phase_in == hcbd_pkg::PH_SIGNED || phase_in == hcbd_pkg::PH_DIGITS
                         || phase_in == hcbd_pkg::PH_XPREF) begin
               phase_in = hcbd_pkg::PH_IGNORE;
            end
         end
         if (!line_done) begin
            if (in_byte_ff == hcbd_pkg::CHAR_CR) begin
               crp_in = 1'b1;
            end else begin
               priority if (phase_in == hcbd_pkg::PH_LEAD && hcbd_pkg::is_space(in_byte_ff)) begin
               end else if (phase_in == hcbd_pkg::PH_LEAD
                            && (in_byte_ff == hcbd_pkg::CHAR_PLUS
                                || in_byte_ff == hcbd_pkg::CHAR_MINUS)) begin
                  neg_in   = (in_byte_ff == hcbd_pkg::CHAR_MINUS);
                  phase_in = hcbd_pkg::PH_SIGNED;
               end else if (phase_in == hcbd_pkg::PH_LEAD
                            || phase_in == hcbd_pkg::PH_SIGNED) begin
                  if (hx.ok) begin
                     lz_in    = (hx.value == 4'd0);
                     acc_in   = acc_digit;
                     phase_in = hcbd_pkg::PH_DIGITS;
                  end else begin
                     phase_in = hcbd_pkg::PH_IGNORE;
                  end
               end else if (phase_in == hcbd_pkg::PH_DIGITS) begin
                  if (hx.ok) begin
                     lz_in  = 1'b0;
                     acc_in = acc_digit;
                  end else if (lz_ff && (in_byte_ff == hcbd_pkg::CHAR_X_LO
                                         || in_byte_ff == hcbd_pkg::CHAR_X_UP)) begin
                     lz_in    = 1'b0;
                     phase_in = hcbd_pkg::PH_XPREF;
                  end else begin
                     phase_in = hcbd_pkg::PH_IGNORE;
                  end
               end else if (phase_in == hcbd_pkg::PH_XPREF) begin
                  if (hx.ok) begin
                     acc_in   = acc_digit;
                     phase_in = hcbd_pkg::PH_DIGITS;
                  end else begin
                     phase_in = hcbd_pkg::PH_IGNORE;
                  end
               end else begin
               end
            end
         end
      end

      if (in_last_ff) begin
         priority if (phase_in == hcbd_pkg::PH_DONE) begin
            out_in.end_status = hcbd_pkg::END_TERMINATOR;
         end else if (phase_in == hcbd_pkg::PH_TRAIL) begin
            out_in.end_status = hcbd_pkg::END_BOUNDARY;
         end else if (phase_in == hcbd_pkg::PH_LEAD && !crp_in) begin
            out_in.end_status = hcbd_pkg::END_BOUNDARY;
         end else begin
            out_in.end_status = hcbd_pkg::END_TRUNCATED;
         end
         phase_in = hcbd_pkg::PH_LEAD;
         acc_in   = '0;
         neg_in   = 1'b0;
         lz_in    = 1'b0;
         crp_in   = 1'b0;
         rem_in   = '0;
      end

      emit = out_in.byte_valid || out_in.end_valid;
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (process) begin
         out_valid_in = emit;
      end else if (rsp_stream.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         phase_ff     <= hcbd_pkg::PH_LEAD;
         acc_ff       <= '0;
         neg_ff       <= 1'b0;
         lz_ff        <= 1'b0;
         crp_ff       <= 1'b0;
         rem_ff       <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (process) begin
            phase_ff <= phase_in;
            acc_ff   <= acc_in;
            neg_ff   <= neg_in;
            lz_ff    <= lz_in;
            crp_ff   <= crp_in;
            rem_ff   <= rem_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_stream.valid && req_stream.ready) begin
         in_byte_ff <= req_stream.payload.in_byte;
         in_last_ff <= req_stream.payload.in_last;
      end
      if (process && emit) begin
         out_ff <= out_in;
      end
   end

   `HCBD_ASSERT_IMP(a_no_empty_rsp, clock, reset, out_valid_ff,
      out_ff.byte_valid || out_ff.end_valid)
   `HCBD_ASSERT_NXT(a_last_restarts, clock, reset, process && in_last_ff,
      phase_ff == hcbd_pkg::PH_LEAD && !crp_ff && acc_ff == '0)
   `HCBD_ASSERT_NXT(a_data_gives_byte, clock, reset, process && phase_ff == hcbd_pkg::PH_DATA,
      out_valid_ff && out_ff.byte_valid)
   `HCBD_ASSERT_IMP(a_data_count_live, clock, reset, phase_ff == hcbd_pkg::PH_DATA,
      rem_ff != '0)

endmodule

// File: test/http_chunked_body_decoder_tb.sv
`timescale 1ns / 1ps

module http_chunked_body_decoder_tb;

   localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
   localparam logic [7:0] CHAR_DIGIT_9 = 8'h39;
   localparam logic [7:0] CHAR_A_LO    = 8'h61;
   localparam logic [7:0] CHAR_F_LO    = 8'h66;
   localparam logic [7:0] CHAR_A_UP    = 8'h41;
   localparam logic [7:0] CHAR_F_UP    = 8'h46;
   localparam logic [7:0] CHAR_SEMI    = 8'h3b;
   localparam int         PHASE_BYTES  = 125;

   class chunk_decode_scoreboard;
      logic [2:0]                phase;
      logic [31:0]               size_acc;
      logic                      negative;
      logic                      lone_zero;
      logic                      cr_held;
      logic [31:0]               remaining;
      hcbd_pkg::rsp_payload_type pending[$];
      int                        mismatches;
      int                        checked;

      function new();
         mismatches = 0;
         checked    = 0;
         clear_state();
      endfunction

      function void clear_state();
         phase     = hcbd_pkg::PH_LEAD;
         size_acc  = '0;
         negative  = 1'b0;
         lone_zero = 1'b0;
         cr_held   = 1'b0;
         remaining = '0;
      endfunction

      function int hex_of(logic [7:0] b);
         if (b >= CHAR_DIGIT_0 && b <= CHAR_DIGIT_9) return int'(b - CHAR_DIGIT_0);
         if (b >= CHAR_A_LO && b <= CHAR_F_LO) return int'(b - CHAR_A_LO) + 10;
         if (b >= CHAR_A_UP && b <= CHAR_F_UP) return int'(b - CHAR_A_UP) + 10;
         return -1;
      endfunction

      function void push_digit(int d);
         if (size_acc > 32'h0fff_ffff) begin
            size_acc = 32'hffff_ffff;
         end else begin
            size_acc = {size_acc[27:0], 4'(d)};
         end
      endfunction

      function void close_line();
         if (negative || size_acc == 0) begin
            phase = hcbd_pkg::PH_DONE;
         end else begin
            remaining = size_acc;
            phase     = hcbd_pkg::PH_DATA;
         end
         size_acc  = '0;
         negative  = 1'b0;
         lone_zero = 1'b0;
      endfunction

      function void size_char(logic [7:0] b);
         int d;
         d = hex_of(b);
         if (phase == hcbd_pkg::PH_LEAD) begin
            if (b == hcbd_pkg::CHAR_SPACE || b == hcbd_pkg::CHAR_TAB
                  || b == hcbd_pkg::CHAR_LF || b == hcbd_pkg::CHAR_VT
                  || b == hcbd_pkg::CHAR_FF || b == hcbd_pkg::CHAR_CR) return;
            if (b == hcbd_pkg::CHAR_PLUS || b == hcbd_pkg::CHAR_MINUS) begin
               negative = (b == hcbd_pkg::CHAR_MINUS);
               phase    = hcbd_pkg::PH_SIGNED;
               return;
            end
         end
         case (phase)
            hcbd_pkg::PH_LEAD, hcbd_pkg::PH_SIGNED: begin
               if (d < 0) begin
                  phase = hcbd_pkg::PH_IGNORE;
               end else begin
                  lone_zero = (d == 0);
                  push_digit(d);
                  phase = hcbd_pkg::PH_DIGITS;
               end
            end
            hcbd_pkg::PH_DIGITS: begin
               if (d >= 0) begin
                  lone_zero = 1'b0;
                  push_digit(d);
               end else if ((b == hcbd_pkg::CHAR_X_LO || b == hcbd_pkg::CHAR_X_UP)
                            && lone_zero) begin
                  lone_zero = 1'b0;
                  phase     = hcbd_pkg::PH_XPREF;
               end else begin
                  phase = hcbd_pkg::PH_IGNORE;
               end
            end
            hcbd_pkg::PH_XPREF: begin
               if (d >= 0) begin
                  push_digit(d);
                  phase = hcbd_pkg::PH_DIGITS;
               end else begin
                  phase = hcbd_pkg::PH_IGNORE;
               end
            end
            default: ;
         endcase
      endfunction

      function void size_line_byte(logic [7:0] b);
         if (cr_held) begin
            cr_held = 1'b0;
            if (b == hcbd_pkg::CHAR_LF) begin
               close_line();
               return;
            end
            size_char(hcbd_pkg::CHAR_CR);
         end
         if (b == hcbd_pkg::CHAR_CR) begin
            cr_held = 1'b1;
            return;
         end
         size_char(b);
      endfunction

      function void note_body_byte(hcbd_pkg::req_payload_type r);
         hcbd_pkg::rsp_payload_type res;
         logic [7:0]                b;
         b   = r.in_byte;
         res = '0;
         case (phase)
            hcbd_pkg::PH_DATA: begin
               res.out_byte   = b;
               res.byte_valid = 1'b1;
               remaining      = remaining - 1;
               if (remaining == 0) phase = hcbd_pkg::PH_TRAIL;
            end
            hcbd_pkg::PH_TRAIL: begin
               if (cr_held) begin
                  cr_held = 1'b0;
                  phase   = hcbd_pkg::PH_LEAD;
                  if (b != hcbd_pkg::CHAR_LF) size_line_byte(b);
               end else if (b == hcbd_pkg::CHAR_CR) begin
                  cr_held = 1'b1;
               end else begin
                  phase = hcbd_pkg::PH_LEAD;
                  size_line_byte(b);
               end
            end
            hcbd_pkg::PH_DONE: ;
            default: size_line_byte(b);
         endcase
         if (r.in_last) begin
            res.end_valid = 1'b1;
            if (phase == hcbd_pkg::PH_DONE) res.end_status = hcbd_pkg::END_TERMINATOR;
            else if (phase == hcbd_pkg::PH_TRAIL) res.end_status = hcbd_pkg::END_BOUNDARY;
            else if (phase == hcbd_pkg::PH_LEAD && !cr_held) begin
               res.end_status = hcbd_pkg::END_BOUNDARY;
            end
            else res.end_status = hcbd_pkg::END_TRUNCATED;
            clear_state();
         end
         if (res.byte_valid || res.end_valid) pending.push_back(res);
      endfunction

      function void check_decoded(hcbd_pkg::rsp_payload_type got);
         hcbd_pkg::rsp_payload_type exp;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("%0t: unexpected result byte=%02h bv=%0b ev=%0b st=%0d", $realtime,
                  got.out_byte, got.byte_valid, got.end_valid, got.end_status);
            end
            return;
         end
         exp = pending.pop_front();
         checked++;
         if (got.out_byte !== exp.out_byte || got.byte_valid !== exp.byte_valid
               || got.end_valid !== exp.end_valid || got.end_status !== exp.end_status) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("%0t: mismatch exp byte=%02h bv=%0b ev=%0b st=%0d", $realtime,
                  exp.out_byte, exp.byte_valid, exp.end_valid, exp.end_status);
               $display("%0t:          got byte=%02h bv=%0b ev=%0b st=%0d", $realtime,
                  got.out_byte, got.byte_valid, got.end_valid, got.end_status);
            end
         end
      endfunction
   endclass

   logic clock;
   logic reset;

   hcbd_stream_if #(.payload_type(hcbd_pkg::req_payload_type)) req_if ();
   hcbd_stream_if #(.payload_type(hcbd_pkg::rsp_payload_type)) rsp_if ();

   http_chunked_body_decoder #(
      .CHUNK_SIZE_BITS(32)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_stream(req_if.sink),
      .rsp_stream(rsp_if.source)
   );

   chunk_decode_scoreboard sb;
   int                     idle_pct;
   int                     stall_pct;
   int                     bytes_sent;
   int                     bodies_sent;
   logic [7:0]             body_bytes[$];

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("timeout with %0d results outstanding", sb.pending.size());
      $display("== FAIL ==");
      $finish;
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_if.valid && req_if.ready) sb.note_body_byte(req_if.payload);
         if (rsp_if.valid && rsp_if.ready) sb.check_decoded(rsp_if.payload);
      end
   end

   task automatic send_byte(input logic [7:0] b, input logic is_end);
      hcbd_pkg::req_payload_type p;
      p.in_byte = b;
      p.in_last = is_end;
      while ($urandom_range(99) < idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.payload <= p;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      bytes_sent++;
   endtask

   task automatic send_body();
      for (int i = 0; i < body_bytes.size(); i++) begin
         send_byte(body_bytes[i], i == body_bytes.size() - 1);
      end
      body_bytes.delete();
      bodies_sent++;
   endtask

   task automatic wait_for_results();
      req_if.valid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   function void push_text(string s);
      for (int i = 0; i < s.len(); i++) body_bytes.push_back(s[i]);
   endfunction

   function void push_crlf();
      body_bytes.push_back(hcbd_pkg::CHAR_CR);
      body_bytes.push_back(hcbd_pkg::CHAR_LF);
   endfunction

   function logic [7:0] hex_char(int unsigned n, bit upper);
      if (n < 10) return CHAR_DIGIT_0 + 8'(n);
      return (upper ? CHAR_A_UP : CHAR_A_LO) + 8'(n - 10);
   endfunction

   function void push_filler();
      int n;
      n = $urandom_range(4, 1);
      body_bytes.push_back(CHAR_SEMI);
      repeat (n) body_bytes.push_back(8'($urandom_range(8'h7e, 8'h20)));
   endfunction

   function void push_size_line(int unsigned chunk_len);
      int unsigned top;
      bit          upper;
      upper = $urandom_range(1);
      case ($urandom_range(11))
         0: body_bytes.push_back(hcbd_pkg::CHAR_SPACE);
         1: body_bytes.push_back(hcbd_pkg::CHAR_TAB);
         2: begin
            body_bytes.push_back(hcbd_pkg::CHAR_CR);
            body_bytes.push_back(hcbd_pkg::CHAR_VT);
         end
         3: body_bytes.push_back(hcbd_pkg::CHAR_FF);
         4: body_bytes.push_back(hcbd_pkg::CHAR_LF);
         default: ;
      endcase
      if ($urandom_range(7) == 0) body_bytes.push_back(hcbd_pkg::CHAR_PLUS);
      if ($urandom_range(5) == 0) begin
         body_bytes.push_back(CHAR_DIGIT_0);
         body_bytes.push_back(upper ? hcbd_pkg::CHAR_X_UP : hcbd_pkg::CHAR_X_LO);
      end
      if ($urandom_range(5) == 0) body_bytes.push_back(CHAR_DIGIT_0);
      top = 0;
      while ((chunk_len >> (4 * (top + 1))) != 0) top++;
      for (int i = int'(top); i >= 0; i--) begin
         body_bytes.push_back(hex_char((chunk_len >> (4 * i)) & 4'hf, upper));
      end
      if ($urandom_range(3) == 0) push_filler();
      push_crlf();
   endfunction

   function void build_random_body();
      int unsigned pick;
      int unsigned chunks;
      int unsigned chunk_len;
      int unsigned cut;
      pick = $urandom_range(99);
      if (pick < 12) begin
         repeat ($urandom_range(16, 1)) begin
            case ($urandom_range(7))
               0: body_bytes.push_back(hcbd_pkg::CHAR_CR);
               1: body_bytes.push_back(hcbd_pkg::CHAR_LF);
               2: body_bytes.push_back(hcbd_pkg::CHAR_MINUS);
               3: body_bytes.push_back(hex_char($urandom_range(15), $urandom_range(1)));
               default: body_bytes.push_back(8'($urandom_range(255)));
            endcase
         end
      end else if (pick < 17) begin
         if ($urandom_range(1)) push_text("0x");
         body_bytes.push_back(CHAR_F_UP);
         repeat ($urandom_range(10, 8)) begin
            body_bytes.push_back(hex_char($urandom_range(15), $urandom_range(1)));
         end
         if ($urandom_range(1)) push_filler();
         push_crlf();
         repeat ($urandom_range(6)) body_bytes.push_back(8'($urandom_range(255)));
      end else begin
         chunks = $urandom_range(3);
         repeat (chunks) begin
            chunk_len = ($urandom_range(9) == 0) ? $urandom_range(40, 1) : $urandom_range(8, 1);
            push_size_line(chunk_len);
            repeat (chunk_len) body_bytes.push_back(8'($urandom_range(255)));
            case ($urandom_range(9))
               7: ;
               8: body_bytes.push_back(hcbd_pkg::CHAR_CR);
               9: body_bytes.push_back(hcbd_pkg::CHAR_LF);
               default: push_crlf();
            endcase
         end
         case ($urandom_range(7))
            0: push_text("-3");
            1: push_text("+");
            2: push_text("0x");
            3: push_text("00");
            4: push_text(" ");
            default: push_text("0");
         endcase
         if ($urandom_range(3) == 0) push_filler();
         push_crlf();
         repeat ($urandom_range(3)) body_bytes.push_back(8'($urandom_range(255)));
         if ($urandom_range(4) == 0) begin
            cut = $urandom_range(body_bytes.size(), 1);
            while (body_bytes.size() > cut) void'(body_bytes.pop_back());
         end
      end
   endfunction

   initial begin
      int phase_start;
      int drain_cycles;
      sb              = new();
      idle_pct        = 0;
      stall_pct       = 0;
      bytes_sent      = 0;
      bodies_sent     = 0;
      reset           = 1'b1;
      req_if.valid    = 1'b0;
      req_if.payload  = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // data at both byte extremes, no crlf after data, negative size ends the body
      push_text("2");
      push_crlf();
      body_bytes.push_back(8'h00);
      body_bytes.push_back(8'hff);
      push_text("-");
      push_crlf();
      push_text("z");
      send_body();
      // prefix without digits
      push_text("0x");
      push_crlf();
      send_body();
      // ends on a lone cr after data
      push_text("1");
      push_crlf();
      push_text("a");
      body_bytes.push_back(hcbd_pkg::CHAR_CR);
      send_body();
      // saturating size line cut short
      push_text("FFFFFFFFF");
      send_body();
      wait_for_results();

      for (int p = 0; p < 4; p++) begin
         case (p)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 47; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 47; end
            default: begin idle_pct = 12; stall_pct = 12; end
         endcase
         phase_start = bytes_sent;
         while (bytes_sent - phase_start < PHASE_BYTES) begin
            build_random_body();
            send_body();
         end
         // sender holds off until the block has drained
         wait_for_results();
      end

      req_if.valid <= 1'b0;
      drain_cycles = 0;
      while (sb.pending.size() != 0 && drain_cycles < 10000) begin
         @(posedge clock);
         drain_cycles++;
      end
      repeat (8) @(posedge clock);
      if (sb.pending.size() != 0) begin
         $display("%0d expected results never arrived", sb.pending.size());
         sb.mismatches += sb.pending.size();
      end

      $display("sent %0d bodies (%0d bytes) over four idle and stall mixes", bodies_sent,
         bytes_sent);
      $display("checked %0d results, %0d mismatches", sb.checked, sb.mismatches);
      if (sb.mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
